[hw/rtl/imd_pkg.sv]
// imu motion detector package: widths, fixed-point constants, register indexes
// no dependencies; imported by imd_isqrt and imu_motion_detector_core
`default_nettype none

package imd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int MAX_CALIB   = 4096;
	localparam int MAX_HOLD    = 255;

	localparam int FILT_W  = SAMPLE_BITS + FRAC_BITS;
	localparam int CALIB_W = 13;
	localparam int SUM_W   = SAMPLE_BITS + CALIB_W;
	localparam int DVD_W   = SUM_W + FRAC_BITS;
	localparam int HOLD_W  = 8;
	localparam int SQ_W    = 32;
	localparam int ROOT_W  = 16;

	typedef enum logic [2:0] {
		REG_FILTER_ALPHA = 3'd0,
		REG_CALIB_COUNT  = 3'd1,
		REG_ACCEL_ENTER  = 3'd2,
		REG_GYRO_ENTER   = 3'd3,
		REG_ACCEL_CLEAR  = 3'd4,
		REG_GYRO_CLEAR   = 3'd5,
		REG_ENTER_HOLD   = 3'd6,
		REG_CLEAR_HOLD   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] root;
	} sqrt_res_t;

endpackage

`default_nettype wire

[hw/rtl/imu_motion_detector_core.sv]
// imu motion detector top level: calibration, per-axis ema, magnitudes, hysteresis
// depends on imd_pkg and imd_isqrt
`default_nettype none

// One request carries a six-axis sample. The first calib_count requests after
// reset only accumulate; the last of them divides the sums (one bit-serial
// divider for all six axes) and measures the rest magnitude, and gives no
// result. Every later request runs six ema updates through the shared
// multiplier, then per vector three squares through the same multiplier and
// a pass through the square-root unit, then the decision state. in_ready is
// high only while the sequencer is idle; a finished result waits in the
// output register and only blocks the sequencer when a second result is
// ready before the first is taken. A configuration write is used at once,
// also by a request that is in progress.
module imu_motion_detector_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] rate_x,
	input  wire logic signed [15:0] rate_y,
	input  wire logic signed [15:0] rate_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] filt_accel_x,
	output logic signed [15:0] filt_accel_y,
	output logic signed [15:0] filt_accel_z,
	output logic signed [15:0] filt_rate_x,
	output logic signed [15:0] filt_rate_y,
	output logic signed [15:0] filt_rate_z,
	output logic [15:0]      accel_mag,
	output logic [15:0]      rate_mag,
	output logic             motion
);
	import imd_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_DIV_LOAD = 11'b00000000010,
		ST_DIV_RUN  = 11'b00000000100,
		ST_DIV_STOR = 11'b00000001000,
		ST_EMA_MUL  = 11'b00000010000,
		ST_EMA_UPD  = 11'b00000100000,
		ST_SQ_MUL   = 11'b00001000000,
		ST_SQ_ACC   = 11'b00010000000,
		ST_SQRT     = 11'b00100000000,
		ST_DECIDE   = 11'b01000000000,
		ST_UNUSED   = 11'b10000000000
	} state_t;

	localparam int PROD_W = FILT_W + 1 + 17;
	localparam int CNT_W  = $clog2(DVD_W);

	// saturate a signed value to the sample range
	function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [SAMPLE_BITS+1:0] v);
		logic signed [SAMPLE_BITS+1:0] hi, lo;
		hi = (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1);
		lo = -hi - $signed((SAMPLE_BITS+2)'(1));
		if (v > hi) return hi[SAMPLE_BITS-1:0];
		if (v < lo) return lo[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

	// filter value to input units, ties toward plus infinity
	function automatic logic signed [SAMPLE_BITS-1:0] axis_out(input logic signed [FILT_W-1:0] f);
		logic signed [FILT_W:0] t;
		t = {f[FILT_W-1], f} + (FILT_W+1)'(1 << (FRAC_BITS-1));
		return sat_s((SAMPLE_BITS+2)'(t >>> FRAC_BITS));
	endfunction

	// configuration registers
	logic [15:0]        alpha_q, acc_enter_q, gyr_enter_q, acc_clear_q, gyr_clear_q;
	logic [CALIB_W-1:0] calib_cnt_q;
	logic [HOLD_W-1:0]  enter_hold_q, clear_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= 16'd6554;
			calib_cnt_q  <= CALIB_W'(100);
			acc_enter_q  <= 16'd205;
			gyr_enter_q  <= 16'd160;
			acc_clear_q  <= 16'd82;
			gyr_clear_q  <= 16'd64;
			enter_hold_q <= HOLD_W'(5);
			clear_hold_q <= HOLD_W'(20);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FILTER_ALPHA: alpha_q      <= cfg_data;
				REG_CALIB_COUNT:  calib_cnt_q  <= cfg_data[CALIB_W-1:0];
				REG_ACCEL_ENTER:  acc_enter_q  <= cfg_data;
				REG_GYRO_ENTER:   gyr_enter_q  <= cfg_data;
				REG_ACCEL_CLEAR:  acc_clear_q  <= cfg_data;
				REG_GYRO_CLEAR:   gyr_clear_q  <= cfg_data;
				REG_ENTER_HOLD:   enter_hold_q <= cfg_data[HOLD_W-1:0];
				REG_CLEAR_HOLD:   clear_hold_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath state
	state_t                         state_q;
	logic [2:0]                     axis_q;
	logic [1:0]                     k_q;
	logic                           mag_sel_q;
	logic [CNT_W-1:0]               cnt_q;
	logic signed [SAMPLE_BITS-1:0]  x_q [6];
	logic signed [SUM_W-1:0]        sum_q [6];
	logic signed [FILT_W-1:0]       filt_q [6];
	logic signed [SAMPLE_BITS-1:0]  bias_q [3];
	logic [CALIB_W-1:0]             seen_q;
	logic                           cal_q;
	logic [15:0]                    rest_q, amag_q, rmag_q;
	logic                           flag_q;
	logic [HOLD_W-1:0]              erun_q, crun_q;
	logic [DVD_W-1:0]               quo_q;
	logic [CALIB_W-1:0]             rem_q;
	logic                           neg_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic [SQ_W-1:0]                sumsq_q;
	logic                           out_valid_q;

	logic signed [SAMPLE_BITS-1:0]  in_x [6];
	assign in_x[0] = accel_x;
	assign in_x[1] = accel_y;
	assign in_x[2] = accel_z;
	assign in_x[3] = rate_x;
	assign in_x[4] = rate_y;
	assign in_x[5] = rate_z;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// calibration length, zero acts as one, clamped to the maximum
	logic [CALIB_W-1:0] need, seen_n;
	always_comb begin
		need = calib_cnt_q;
		if (need == '0) need = CALIB_W'(1);
		if (need > CALIB_W'(MAX_CALIB)) need = CALIB_W'(MAX_CALIB);
		seen_n = seen_q + 1'b1;
	end

	// divider: magnitude of the sum (scaled for accel) plus half the count
	logic [SUM_W-1:0]   sum_abs;
	logic [DVD_W-1:0]   dvd;
	logic [CALIB_W:0]   rshift;
	logic [DVD_W:0]     qsigned;
	always_comb begin
		sum_abs = sum_q[axis_q][SUM_W-1] ? SUM_W'(-sum_q[axis_q]) : SUM_W'(sum_q[axis_q]);
		if (axis_q < 3'd3)
			dvd = {sum_abs, {FRAC_BITS{1'b0}}};
		else
			dvd = DVD_W'(sum_abs);
		dvd     = dvd + DVD_W'(seen_q >> 1);
		rshift  = {rem_q, quo_q[DVD_W-1]};
		qsigned = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
	end

	// shared multiplier operands
	logic signed [FILT_W:0]         mul_a;
	logic signed [16:0]             mul_b;
	logic signed [SAMPLE_BITS-1:0]  sq_val;
	logic signed [FILT_W:0]         ema_diff;
	always_comb begin
		sq_val   = axis_out(filt_q[{1'b0, k_q} + (mag_sel_q ? 3'd3 : 3'd0)]);
		ema_diff = (FILT_W+1)'(x_q[axis_q]) * (FILT_W+1)'(1 << FRAC_BITS)
			- (FILT_W+1)'(filt_q[axis_q]);
		if (state_q == ST_EMA_MUL) begin
			mul_a = ema_diff;
			mul_b = $signed({1'b0, alpha_q});
		end else begin
			mul_a = (FILT_W+1)'(sq_val);
			mul_b = 17'(sq_val);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// ema step: add the product rounded at bit 16, ties toward plus infinity
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [FILT_W-1:0] filt_new;
	assign prod_rnd = prod_q + PROD_W'(1 << 15);
	assign filt_new = FILT_W'(filt_q[axis_q] + FILT_W'(prod_rnd >>> 16));

	logic [SQ_W-1:0] sumsq_n;
	assign sumsq_n = (k_q == 2'd0 ? '0 : sumsq_q) + prod_q[SQ_W-1:0];

	logic      sqrt_start;
	sqrt_res_t sqrt_res;
	assign sqrt_start = (state_q == ST_SQ_ACC) && (k_q == 2'd2);

	imd_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sumsq_n),
		.res      (sqrt_res)
	);

	// hysteresis decision
	logic [15:0]       dev;
	logic              cand_m, cand_q, flag_n, go;
	logic [HOLD_W-1:0] erun_n, crun_n;
	always_comb begin
		dev    = (amag_q >= rest_q) ? amag_q - rest_q : rest_q - amag_q;
		cand_m = (dev >= acc_enter_q) || (rmag_q >= gyr_enter_q);
		cand_q = (dev <= acc_clear_q) && (rmag_q <= gyr_clear_q);
		flag_n = flag_q;
		erun_n = '0;
		crun_n = '0;
		if (!flag_q) begin
			if (cand_m) begin
				erun_n = (erun_q < HOLD_W'(MAX_HOLD)) ? erun_q + 1'b1 : erun_q;
				if (erun_n >= enter_hold_q) begin
					flag_n = 1'b1;
					erun_n = '0;
				end
			end
		end else begin
			if (cand_q) begin
				crun_n = (crun_q < HOLD_W'(MAX_HOLD)) ? crun_q + 1'b1 : crun_q;
				if (crun_n >= clear_hold_q) begin
					flag_n = 1'b0;
					crun_n = '0;
				end
			end
		end
		go = !out_valid_q || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			k_q         <= '0;
			mag_sel_q   <= 1'b0;
			cnt_q       <= '0;
			seen_q      <= '0;
			cal_q       <= 1'b0;
			flag_q      <= 1'b0;
			erun_q      <= '0;
			crun_q      <= '0;
			out_valid_q <= 1'b0;
			rest_q      <= '0;
			for (int i = 0; i < 6; i++) begin
				sum_q[i]  <= '0;
				filt_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) bias_q[i] <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						axis_q <= '0;
						if (!cal_q) begin
							// calibration: accumulate, divide on the last sample
							for (int i = 0; i < 6; i++)
								sum_q[i] <= sum_q[i] + SUM_W'(in_x[i]);
							seen_q <= seen_n;
							if (seen_n >= need) state_q <= ST_DIV_LOAD;
						end else begin
							state_q <= ST_EMA_MUL;
						end
					end
				end
				ST_DIV_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DVD_W - 1)) state_q <= ST_DIV_STOR;
				end
				ST_DIV_STOR: begin
					if (axis_q < 3'd3) begin
						filt_q[axis_q] <= qsigned[FILT_W-1:0];
					end else begin
						bias_q[2'(axis_q - 3'd3)] <= qsigned[SAMPLE_BITS-1:0];
						filt_q[axis_q]            <= '0;
					end
					if (axis_q == 3'd5) begin
						mag_sel_q <= 1'b0;
						k_q       <= '0;
						state_q   <= ST_SQ_MUL;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DIV_LOAD;
					end
				end
				ST_EMA_MUL: state_q <= ST_EMA_UPD;
				ST_EMA_UPD: begin
					filt_q[axis_q] <= filt_new;
					if (axis_q == 3'd5) begin
						mag_sel_q <= 1'b0;
						k_q       <= '0;
						state_q   <= ST_SQ_MUL;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_EMA_MUL;
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					if (k_q == 2'd2) begin
						state_q <= ST_SQRT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQRT: begin
					if (sqrt_res.done) begin
						if (mag_sel_q) begin
							state_q <= ST_DECIDE;
						end else if (!cal_q) begin
							// rest level measured, calibration complete
							rest_q  <= sqrt_res.root;
							cal_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							mag_sel_q <= 1'b1;
							k_q       <= '0;
							state_q   <= ST_SQ_MUL;
						end
					end
				end
				ST_DECIDE: begin
					// hold until the output register is free
					if (go) begin
						flag_q      <= flag_n;
						erun_q      <= erun_n;
						crun_q      <= crun_n;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && cal_q) begin
			// latch sample, rate with bias removed and saturated
			for (int i = 0; i < 3; i++) begin
				x_q[i]     <= in_x[i];
				x_q[3 + i] <= sat_s((SAMPLE_BITS+2)'(in_x[3 + i])
					- (SAMPLE_BITS+2)'(bias_q[i]));
			end
		end
		if (state_q == ST_DIV_LOAD) begin
			quo_q <= dvd;
			rem_q <= '0;
			neg_q <= sum_q[axis_q][SUM_W-1];
		end else if (state_q == ST_DIV_RUN) begin
			if (rshift >= {1'b0, seen_q}) begin
				rem_q <= CALIB_W'(rshift - {1'b0, seen_q});
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rshift[CALIB_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
		if (state_q == ST_SQ_ACC) sumsq_q <= sumsq_n;
		if (state_q == ST_SQRT && sqrt_res.done) begin
			if (mag_sel_q) rmag_q <= sqrt_res.root;
			else           amag_q <= sqrt_res.root;
		end
		if (state_q == ST_DECIDE && go) begin
			filt_accel_x <= axis_out(filt_q[0]);
			filt_accel_y <= axis_out(filt_q[1]);
			filt_accel_z <= axis_out(filt_q[2]);
			filt_rate_x  <= axis_out(filt_q[3]);
			filt_rate_y  <= axis_out(filt_q[4]);
			filt_rate_z  <= axis_out(filt_q[5]);
			accel_mag    <= amag_q;
			rate_mag     <= rmag_q;
			motion       <= flag_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/imd_isqrt.sv]
// iterative rounded integer square root, two radicand bits per cycle
// depends on imd_pkg
`default_nettype none

module imd_isqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [imd_pkg::SQ_W-1:0] radicand,
	output imd_pkg::sqrt_res_t            res
);
	import imd_pkg::*;

	localparam int ITERS = SQ_W / 2;
	localparam int IT_W  = $clog2(ITERS);

	logic [SQ_W-1:0] s_q, r_q, bit_q;
	logic [IT_W-1:0] it_q;
	logic            run_q, done_q;
	logic [SQ_W:0]   rb, rnd;
	logic            fits;

	assign rb   = {1'b0, r_q} + {1'b0, bit_q};
	assign fits = {1'b0, s_q} >= rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == IT_W'(ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q   <= radicand;
			r_q   <= '0;
			bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (run_q) begin
			if (fits) begin
				s_q <= s_q - rb[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// round to nearest: remainder above root means the upper neighbor is closer
	assign rnd = {1'b0, r_q} + {{SQ_W{1'b0}}, (s_q > r_q)};

	always_comb begin
		res.done = done_q;
		if (rnd > {{(SQ_W-ROOT_W+1){1'b0}}, {ROOT_W{1'b1}}})
			res.root = '1;
		else
			res.root = rnd[ROOT_W-1:0];
	end

endmodule

`default_nettype wire

[test/tb_imu_motion_detector_core.sv]
// testbench for imu_motion_detector_core: calibration, ema filtering, magnitudes, hysteresis
// depends on imd_pkg and the core rtl; predicts each status result and checks it in order
`default_nettype none

module tb_imu_motion_detector_core;
	import imd_pkg::*;

	localparam int LIMIT_CYCLES  = 1500000;
	localparam int SETTLE_CYCLES = 400;   // longer than the calibration end

	typedef logic signed [15:0] axes_t [6];

	typedef struct packed {
		logic signed [15:0] ax, ay, az, rx, ry, rz;
		logic [15:0]        amag, rmag;
		logic               mot;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] filt_accel_x, filt_accel_y, filt_accel_z;
	logic signed [15:0] filt_rate_x, filt_rate_y, filt_rate_z;
	logic [15:0] accel_mag, rate_mag;
	logic motion;

	imu_motion_detector_core i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready,
		.accel_x, .accel_y, .accel_z, .rate_x, .rate_y, .rate_z,
		.out_valid, .out_ready,
		.filt_accel_x, .filt_accel_y, .filt_accel_z,
		.filt_rate_x, .filt_rate_y, .filt_rate_z,
		.accel_mag, .rate_mag, .motion
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor state: registers, calibration, filters, hysteresis
	// ---------------------------------------------------------------
	logic [15:0] reg_val [8];
	longint calib_sum [6];
	longint calib_n;
	bit     is_calibrated;
	longint rate_offset [3];
	longint ema [6];
	longint rest_mag;
	bit     motion_state;
	int     enter_cnt, clear_cnt;

	status_t status_q [$];

	int errors = 0;
	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_motion_results = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_holdoff = 0;
	longint cycles = 0;

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// round to nearest, ties toward plus infinity (arithmetic shift floors)
	function automatic longint round_shr(longint v, int n);
		if (n == 0) return v;
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// round to nearest, ties away from zero
	function automatic longint div_near(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint axis_value(int i);
		return sat16(round_shr(ema[i], FRAC_BITS));
	endfunction

	// nearest-integer root of the sum of squares, saturated to 16 bits
	function automatic longint norm3(longint a, longint b, longint c);
		longint unsigned s, r, bitv;
		s = longint'(a * a) + longint'(b * b) + longint'(c * c);
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= r + bitv) begin
				s -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		if (s > r) r++;
		return (r > 65535) ? 65535 : longint'(r);
	endfunction

	task automatic predict_sample(input axes_t s);
		longint x [6];
		longint need, a0, a1, a2, r0, r1, r2, amag, rmag, dev;
		bit cand_motion, cand_quiet;
		status_t st;
		for (int i = 0; i < 6; i++) x[i] = sat16(longint'(s[i]));
		if (!is_calibrated) begin
			need = reg_val[REG_CALIB_COUNT];
			if (need == 0) need = 1;
			if (need > MAX_CALIB) need = MAX_CALIB;
			for (int i = 0; i < 6; i++) calib_sum[i] += x[i];
			calib_n++;
			// the sample that ends calibration gives no result
			if (calib_n >= need) begin
				for (int i = 0; i < 3; i++) begin
					ema[i] = div_near(calib_sum[i] * (longint'(1) << FRAC_BITS), calib_n);
					rate_offset[i] = div_near(calib_sum[3 + i], calib_n);
					ema[3 + i] = 0;
				end
				rest_mag = norm3(axis_value(0), axis_value(1), axis_value(2));
				is_calibrated = 1'b1;
			end
			return;
		end
		for (int i = 0; i < 3; i++) x[3 + i] = sat16(x[3 + i] - rate_offset[i]);
		for (int i = 0; i < 6; i++)
			ema[i] += round_shr((x[i] * (longint'(1) << FRAC_BITS) - ema[i])
				* longint'(reg_val[REG_FILTER_ALPHA]), 16);
		a0 = axis_value(0); a1 = axis_value(1); a2 = axis_value(2);
		r0 = axis_value(3); r1 = axis_value(4); r2 = axis_value(5);
		amag = norm3(a0, a1, a2);
		rmag = norm3(r0, r1, r2);
		dev = (amag >= rest_mag) ? amag - rest_mag : rest_mag - amag;
		cand_motion = dev >= reg_val[REG_ACCEL_ENTER] || rmag >= reg_val[REG_GYRO_ENTER];
		cand_quiet = dev <= reg_val[REG_ACCEL_CLEAR] && rmag <= reg_val[REG_GYRO_CLEAR];
		if (!motion_state) begin
			clear_cnt = 0;
			if (cand_motion) begin
				if (enter_cnt < MAX_HOLD) enter_cnt++;
				if (enter_cnt >= reg_val[REG_ENTER_HOLD]) begin
					motion_state = 1'b1;
					enter_cnt = 0;
				end
			end else begin
				enter_cnt = 0;
			end
		end else begin
			enter_cnt = 0;
			if (cand_quiet) begin
				if (clear_cnt < MAX_HOLD) clear_cnt++;
				if (clear_cnt >= reg_val[REG_CLEAR_HOLD]) begin
					motion_state = 1'b0;
					clear_cnt = 0;
				end
			end else begin
				clear_cnt = 0;
			end
		end
		st.ax = a0[15:0]; st.ay = a1[15:0]; st.az = a2[15:0];
		st.rx = r0[15:0]; st.ry = r1[15:0]; st.rz = r2[15:0];
		st.amag = amag[15:0];
		st.rmag = rmag[15:0];
		st.mot = motion_state;
		status_q.push_back(st);
	endtask

	// ---------------------------------------------------------------
	// result checker: every accepted result against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		status_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {filt_accel_x, filt_accel_y, filt_accel_z, filt_rate_x, filt_rate_y,
				filt_rate_z, accel_mag, rate_mag, motion};
			n_checked++;
			if (got.mot) n_motion_results++;
			if (status_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %h", got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp a=%0d,%0d,%0d r=%0d,%0d,%0d am=%0d rm=%0d m=%0b",
							want.ax, want.ay, want.az, want.rx, want.ry, want.rz,
							want.amag, want.rmag, want.mot);
						$display("         got a=%0d,%0d,%0d r=%0d,%0d,%0d am=%0d rm=%0d m=%0b",
							got.ax, got.ay, got.az, got.rx, got.ry, got.rz,
							got.amag, got.rmag, got.mot);
					end
				end
			end
		end
	end

	// receiver: random stalls, plus a long counted hold-off on demand
	always @(posedge clk) begin
		if (recv_holdoff > 0) begin
			out_ready <= 1'b0;
			recv_holdoff <= recv_holdoff - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("imu_motion_detector_core test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// shared stimulus tasks
	// ---------------------------------------------------------------
	// one request; the payload holds until accepted, then an optional gap
	task automatic send_sample(input axes_t s);
		in_valid <= 1'b1;
		accel_x <= s[0]; accel_y <= s[1]; accel_z <= s[2];
		rate_x <= s[3]; rate_y <= s[4]; rate_z <= s[5];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_sample(s);
		n_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// wait for every predicted result, then let the sequencer go idle
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CALIB_COUNT) reg_val[idx] = val & 16'h1fff;
		else if (idx == REG_ENTER_HOLD || idx == REG_CLEAR_HOLD) reg_val[idx] = val & 16'h00ff;
		else reg_val[idx] = val;
		@(posedge clk);
	endtask

	task automatic set_detector(input logic [15:0] alpha, input logic [15:0] a_en,
		input logic [15:0] g_en, input logic [15:0] a_cl, input logic [15:0] g_cl,
		input logic [15:0] en_hold, input logic [15:0] cl_hold);
		write_reg(REG_FILTER_ALPHA, alpha);
		write_reg(REG_ACCEL_ENTER, a_en);
		write_reg(REG_GYRO_ENTER, g_en);
		write_reg(REG_ACCEL_CLEAR, a_cl);
		write_reg(REG_GYRO_CLEAR, g_cl);
		write_reg(REG_ENTER_HOLD, en_hold);
		write_reg(REG_CLEAR_HOLD, cl_hold);
	endtask

	// board lying flat: about 1 g on z, small fixed gyro offset plus noise
	function automatic axes_t rest_sample(int noise);
		axes_t s;
		s[0] = 16'(int'($urandom_range(2 * noise)) - noise);
		s[1] = 16'(int'($urandom_range(2 * noise)) - noise);
		s[2] = 16'(4096 + int'($urandom_range(2 * noise)) - noise);
		s[3] = 16'(20 + int'($urandom_range(2 * noise)) - noise);
		s[4] = 16'(-15 + int'($urandom_range(2 * noise)) - noise);
		s[5] = 16'(3 + int'($urandom_range(2 * noise)) - noise);
		return s;
	endfunction

	function automatic axes_t moving_sample();
		axes_t s;
		s = rest_sample(4);
		for (int i = 0; i < 6; i++) s[i] = s[i] + 16'(int'($urandom_range(6000)) - 3000);
		return s;
	endfunction

	function automatic axes_t noise_sample();
		axes_t s;
		for (int i = 0; i < 6; i++) s[i] = 16'($urandom);
		return s;
	endfunction

	function automatic axes_t make_sample(int a, int b, int c, int d, int e, int f);
		axes_t s;
		s[0] = 16'(a); s[1] = 16'(b); s[2] = 16'(c);
		s[3] = 16'(d); s[4] = 16'(e); s[5] = 16'(f);
		return s;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// calibration count lowered below the samples already seen: the next
	// sample closes calibration and divides by the samples seen
	task automatic test_calibration();
		write_reg(REG_CALIB_COUNT, 16'd6);
		for (int k = 0; k < 4; k++) send_sample(rest_sample(6));
		drain_and_settle();
		write_reg(REG_CALIB_COUNT, 16'd2);
		send_sample(rest_sample(6));
		drain_and_settle();
	endtask

	// field extremes, full-weight filter, bias removal saturation, zero hold
	task automatic test_extremes();
		set_detector(16'hffff, 16'd300, 16'd200, 16'd100, 16'd80, 16'd0, 16'd0);
		send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
		send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		send_sample(make_sample(32767, -32768, 0, -32768, 32767, 0));
		send_sample(make_sample(0, 0, 0, 0, 0, 0));
		send_sample(make_sample(-1, 1, -1, 1, -1, 1));
		send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
		send_sample(make_sample(0, 0, 4096, 20, -15, 3));
		send_sample(make_sample(0, 0, 4096, 20, -15, 3));
		drain_and_settle();
	endtask

	// zero alpha holds the filters; calibration count writes no longer matter
	task automatic test_zero_alpha();
		write_reg(REG_FILTER_ALPHA, 16'd0);
		write_reg(REG_CALIB_COUNT, 16'd0);
		write_reg(REG_CALIB_COUNT, 16'hffff);
		for (int k = 0; k < 4; k++) send_sample(noise_sample());
		drain_and_settle();
		write_reg(REG_FILTER_ALPHA, 16'd1);
		write_reg(REG_CALIB_COUNT, 16'd4096);
		for (int k = 0; k < 4; k++) send_sample(noise_sample());
		drain_and_settle();
	endtask

	// quiet and motion stretches of random length, with some raw noise
	task automatic test_random(input int count);
		bit moving;
		int seg;
		moving = 1'b0;
		seg = 0;
		for (int k = 0; k < count; k++) begin
			if (seg == 0) begin
				moving = ~moving;
				seg = $urandom_range(3, 40);
			end
			seg--;
			if ($urandom_range(99) < 10) send_sample(noise_sample());
			else if (moving) send_sample(moving_sample());
			else send_sample(rest_sample($urandom_range(1, 30)));
		end
		drain_and_settle();
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_holdoff <= 3000;
		for (int k = 0; k < 40; k++) send_sample(moving_sample());
		drain_and_settle();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) reg_val[i] = '0;
		reg_val[REG_FILTER_ALPHA] = 16'd6554;
		reg_val[REG_CALIB_COUNT]  = 16'd100;
		reg_val[REG_ACCEL_ENTER]  = 16'd205;
		reg_val[REG_GYRO_ENTER]   = 16'd160;
		reg_val[REG_ACCEL_CLEAR]  = 16'd82;
		reg_val[REG_GYRO_CLEAR]   = 16'd64;
		reg_val[REG_ENTER_HOLD]   = 16'd5;
		reg_val[REG_CLEAR_HOLD]   = 16'd20;
		for (int i = 0; i < 6; i++) begin
			calib_sum[i] = 0;
			ema[i] = 0;
		end
		for (int i = 0; i < 3; i++) rate_offset[i] = 0;
		calib_n = 0;
		is_calibrated = 1'b0;
		rest_mag = 0;
		motion_state = 1'b0;
		enter_cnt = 0;
		clear_cnt = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 61;
		test_calibration();
		test_extremes();
		test_zero_alpha();

		// reset-like detector setting
		set_detector(16'd6554, 16'd205, 16'd160, 16'd82, 16'd64, 16'd5, 16'd20);
		test_random(320);

		// extremes: each sample a candidate both ways, flag toggles; then max enter limits and holds, clear limits 0
		send_idle_pct = 61;
		recv_idle_pct = 25;
		set_detector(16'hffff, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'd1, 16'd1);
		test_random(150);
		set_detector(16'd40000, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'd255, 16'd255);
		test_random(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_detector(16'd32768, 16'd400, 16'd300, 16'd150, 16'd120, 16'd3, 16'd8);
		test_random(260);
		test_backpressure();

		if (status_q.size() != 0) begin
			errors += status_q.size();
			$display("%0d predicted results never arrived", status_q.size());
		end
		$display("sent %0d samples, checked %0d status results (%0d flagged motion)",
			n_sent, n_checked, n_motion_results);
		$display("covered calibration shrink, extremes, zero alpha, hysteresis and backpressure");
		if (errors == 0) begin
			$display("imu_motion_detector_core test passed");
		end else begin
			$display("imu_motion_detector_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
